/* design/triangle_uv_distortion_color_assert.svh */
// Assertion macros used by the top-level RTL file
`ifndef TRIANGLE_UV_DISTORTION_COLOR_ASSERT_SVH
`define TRIANGLE_UV_DISTORTION_COLOR_ASSERT_SVH

// same-cycle implication, clocked on clk, idle in reset
`define TUVDC_ASSERT_SAME(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tuvdc assertion failed");

// next-cycle implication, clocked on clk, idle in reset
`define TUVDC_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tuvdc assertion failed");

`endif

/* design/tuvdc_pkg.sv */
`default_nettype none

package tuvdc_pkg;

    localparam int LIMB_W = 24;
    localparam int MUL_LAT = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CHAN_W = 8;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_RED   = 3'd0,
        REG_BASE_GREEN = 3'd1,
        REG_BASE_BLUE  = 3'd2,
        REG_GAIN_RED   = 3'd3,
        REG_GAIN_GREEN = 3'd4,
        REG_GAIN_BLUE  = 3'd5
    } cfg_reg_t;

endpackage

`default_nettype wire

/* design/tuvdc_mul.sv */
`default_nettype none

module tuvdc_mul #(
    parameter int AW = 35,
    parameter int BW = 35
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);
    import tuvdc_pkg::*;

    localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
    localparam int NB = (BW + LIMB_W - 1) / LIMB_W;
    localparam int AP = NA * LIMB_W;
    localparam int BP = NB * LIMB_W;
    localparam int RW = (NB + 1) * LIMB_W;
    localparam int TW = (NA + NB) * LIMB_W;

    logic [AP-1:0]         a_pad;
    logic [BP-1:0]         b_pad;
    logic [2*LIMB_W-1:0]   pp_reg  [NA][NB];
    logic [2*LIMB_W-1:0]   pp_next [NA][NB];
    logic [RW-1:0]         row_reg  [NA];
    logic [RW-1:0]         row_next [NA];
    logic [TW-1:0]         tot_next;
    logic [AW+BW-1:0]      prod_reg;

    assign a_pad = AP'(a);
    assign b_pad = BP'(b);

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_next[i][j] = (2*LIMB_W)'(a_pad[i*LIMB_W +: LIMB_W])
                              * (2*LIMB_W)'(b_pad[j*LIMB_W +: LIMB_W]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (j * LIMB_W));
            end
        end
    end

    always_comb
    begin
        tot_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            tot_next = tot_next + (TW'(row_reg[i]) << (i * LIMB_W));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg   <= pp_next;
            row_reg  <= row_next;
            prod_reg <= tot_next[AW+BW-1:0];
        end
    end

    assign p = prod_reg;

endmodule

`default_nettype wire

/* design/triangle_uv_distortion_color.sv */
// Triangle UV distortion colour: one triangle (three vertices, three packed UVs) per
// word in, one RGBA colour plus the Q1.SINE_FRACTION_BITS sine of the angle between
// the UV Jacobian columns per word out. A new triangle is taken every cycle unless the
// output buffer is full and out_ready is low; a result passes through the restoring
// divider (one quotient bit per stage) followed by the square root (one root bit per
// stage). A two-word output buffer keeps input flowing while a result waits. Write
// the base and gain registers only while the block is empty.
`default_nettype none

module triangle_uv_distortion_color #(
    parameter int COORD_WIDTH = 16,
    parameter int SINE_FRACTION_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COORD_WIDTH-1:0]     vertex0_x,
    input  logic signed [COORD_WIDTH-1:0]     vertex0_y,
    input  logic signed [COORD_WIDTH-1:0]     vertex0_z,
    input  logic signed [COORD_WIDTH-1:0]     vertex1_x,
    input  logic signed [COORD_WIDTH-1:0]     vertex1_y,
    input  logic signed [COORD_WIDTH-1:0]     vertex1_z,
    input  logic signed [COORD_WIDTH-1:0]     vertex2_x,
    input  logic signed [COORD_WIDTH-1:0]     vertex2_y,
    input  logic signed [COORD_WIDTH-1:0]     vertex2_z,
    input  logic [2*COORD_WIDTH-1:0]          uv0,
    input  logic [2*COORD_WIDTH-1:0]          uv1,
    input  logic [2*COORD_WIDTH-1:0]          uv2,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tuvdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tuvdc_pkg::CHAN_W-1:0]      cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tuvdc_pkg::CHAN_W-1:0]      red,
    output logic [tuvdc_pkg::CHAN_W-1:0]      green,
    output logic [tuvdc_pkg::CHAN_W-1:0]      blue,
    output logic [tuvdc_pkg::CHAN_W-1:0]      alpha,
    output logic [SINE_FRACTION_BITS:0]       distortion
);
    import tuvdc_pkg::*;
    `include "triangle_uv_distortion_color_assert.svh"

    localparam int W    = COORD_WIDTH;
    localparam int F    = SINE_FRACTION_BITS;
    localparam int EW   = W + 1;
    localparam int PW   = 2 * W + 1;
    localparam int DW   = 2 * W + 2;
    localparam int MW   = 2 * W + 1;
    localparam int SQW  = 2 * MW;
    localparam int NW   = SQW + 2;
    localparam int DTW  = NW + 1;
    localparam int DENW = 2 * NW;
    localparam int RMW  = DENW + 1;
    localparam int QW   = 2 * F + 1;
    localparam int SW   = F + 1;
    localparam int SQ2W = 2 * SW;
    localparam int RESW = 3 * CHAN_W + SW;
    localparam logic [SW-1:0] ONE   = {1'b1, {F{1'b0}}};
    localparam logic [QW-1:0] Q_MAX = {1'b1, {(2*F){1'b0}}};

    function automatic logic [CHAN_W-1:0] chan_mix(
        input logic [CHAN_W-1:0] base,
        input logic [CHAN_W-1:0] gain,
        input logic [SW-1:0]     s
    );
        logic [CHAN_W+SW-1:0] prod;
        logic [CHAN_W+1:0]    sum;
        prod = (CHAN_W+SW)'(gain) * (CHAN_W+SW)'(s);
        sum  = (CHAN_W+2)'(base) + (CHAN_W+2)'(prod[CHAN_W+SW-1:F]);
        return (sum > (CHAN_W+2)'(CHAN_MAX)) ? CHAN_MAX : sum[CHAN_W-1:0];
    endfunction

    // configuration
    logic [CHAN_W-1:0] base_red_reg, base_green_reg, base_blue_reg;
    logic [CHAN_W-1:0] gain_red_reg, gain_green_reg, gain_blue_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_red_reg   <= '0;
            base_green_reg <= '0;
            base_blue_reg  <= '0;
            gain_red_reg   <= CHAN_MAX;
            gain_green_reg <= CHAN_MAX;
            gain_blue_reg  <= CHAN_MAX;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BASE_RED:   base_red_reg   <= cfg_data;
                REG_BASE_GREEN: base_green_reg <= cfg_data;
                REG_BASE_BLUE:  base_blue_reg  <= cfg_data;
                REG_GAIN_RED:   gain_red_reg   <= cfg_data;
                REG_GAIN_GREEN: gain_green_reg <= cfg_data;
                REG_GAIN_BLUE:  gain_blue_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance and output buffer control
    logic       en;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    logic       wr_idx;

    assign en       = (cnt_reg != 2'd2) || out_ready;
    assign in_ready = en;

    // stage 1: edges
    logic signed [W-1:0]  p0 [3];
    logic signed [W-1:0]  p1 [3];
    logic signed [W-1:0]  p2 [3];
    logic signed [W-1:0]  u0, v0, u1, v1, u2, v2;
    logic                 v1_reg;
    logic signed [EW-1:0] e1_reg [3], e1_next [3];
    logic signed [EW-1:0] e2_reg [3], e2_next [3];
    logic signed [EW-1:0] t1u_reg, t1v_reg, t2u_reg, t2v_reg;
    logic signed [EW-1:0] t1u_next, t1v_next, t2u_next, t2v_next;

    assign p0[0] = vertex0_x;
    assign p0[1] = vertex0_y;
    assign p0[2] = vertex0_z;
    assign p1[0] = vertex1_x;
    assign p1[1] = vertex1_y;
    assign p1[2] = vertex1_z;
    assign p2[0] = vertex2_x;
    assign p2[1] = vertex2_y;
    assign p2[2] = vertex2_z;
    assign u0 = uv0[2*W-1:W];
    assign v0 = uv0[W-1:0];
    assign u1 = uv1[2*W-1:W];
    assign v1 = uv1[W-1:0];
    assign u2 = uv2[2*W-1:W];
    assign v2 = uv2[W-1:0];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1_next[k] = EW'(p1[k]) - EW'(p0[k]);
            e2_next[k] = EW'(p2[k]) - EW'(p0[k]);
        end
        t1u_next = EW'(u1) - EW'(u0);
        t1v_next = EW'(v1) - EW'(v0);
        t2u_next = EW'(u2) - EW'(u0);
        t2v_next = EW'(v2) - EW'(v0);
    end

    // stage 2: adjugate products
    logic                 v2_reg;
    logic signed [PW-1:0] pa_reg [3], pb_reg [3], pc_reg [3], pd_reg [3];
    logic signed [PW-1:0] pa_next [3], pb_next [3], pc_next [3], pd_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pa_next[k] = PW'(t2v_reg) * PW'(e1_reg[k]);
            pb_next[k] = PW'(t1v_reg) * PW'(e2_reg[k]);
            pc_next[k] = PW'(t2u_reg) * PW'(e1_reg[k]);
            pd_next[k] = PW'(t1u_reg) * PW'(e2_reg[k]);
        end
    end

    // stage 3: Jacobian columns
    logic                 v3_reg;
    logic signed [DW-1:0] du_reg [3], du_next [3];
    logic signed [DW-1:0] dv_reg [3], dv_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            du_next[k] = DW'(pa_reg[k]) - DW'(pb_reg[k]);
            dv_next[k] = DW'(pd_reg[k]) - DW'(pc_reg[k]);
        end
    end

    // stage 4: magnitudes, signs, zero column
    logic          v4_reg, z4_reg, z4_next;
    logic [MW-1:0] dum_reg [3], dum_next [3];
    logic [MW-1:0] dvm_reg [3], dvm_next [3];
    logic [2:0]    sg4_reg, sg4_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dum_next[k] = du_reg[k][DW-1] ? MW'(-du_reg[k]) : MW'(du_reg[k]);
            dvm_next[k] = dv_reg[k][DW-1] ? MW'(-dv_reg[k]) : MW'(dv_reg[k]);
            sg4_next[k] = du_reg[k][DW-1] ^ dv_reg[k][DW-1];
        end
        z4_next = ((du_reg[0] == '0) && (du_reg[1] == '0) && (du_reg[2] == '0))
               || ((dv_reg[0] == '0) && (dv_reg[1] == '0) && (dv_reg[2] == '0));
    end

    // squares and dot terms
    logic [SQW-1:0] squ [3], sqv [3], dpr [3];
    logic           m1_v_reg  [MUL_LAT];
    logic           m1_z_reg  [MUL_LAT];
    logic [2:0]     m1_sg_reg [MUL_LAT];

    for (genvar k = 0; k < 3; k++)
    begin : g_mul1
        tuvdc_mul #(.AW(MW), .BW(MW)) u_squ (
            .clk(clk), .en(en), .a(dum_reg[k]), .b(dum_reg[k]), .p(squ[k])
        );
        tuvdc_mul #(.AW(MW), .BW(MW)) u_sqv (
            .clk(clk), .en(en), .a(dvm_reg[k]), .b(dvm_reg[k]), .p(sqv[k])
        );
        tuvdc_mul #(.AW(MW), .BW(MW)) u_dot (
            .clk(clk), .en(en), .a(dum_reg[k]), .b(dvm_reg[k]), .p(dpr[k])
        );
    end

    // stage 5: norms and dot magnitude
    logic                  v5_reg, z5_reg;
    logic [NW-1:0]         nu_reg, nv_reg, dotm_reg;
    logic [NW-1:0]         nu_next, nv_next, dotm_next;
    logic signed [DTW-1:0] dots;

    always_comb
    begin
        nu_next = NW'(squ[0]) + NW'(squ[1]) + NW'(squ[2]);
        nv_next = NW'(sqv[0]) + NW'(sqv[1]) + NW'(sqv[2]);
        dots = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (m1_sg_reg[MUL_LAT-1][k])
                dots = dots - DTW'(dpr[k]);
            else
                dots = dots + DTW'(dpr[k]);
        end
        dotm_next = dots[DTW-1] ? NW'(-dots) : NW'(dots);
    end

    // norm product and squared dot
    logic [DENW-1:0] den_w, dd_w;
    logic            m2_v_reg [MUL_LAT];
    logic            m2_z_reg [MUL_LAT];

    tuvdc_mul #(.AW(NW), .BW(NW)) u_den (
        .clk(clk), .en(en), .a(nu_reg), .b(nv_reg), .p(den_w)
    );
    tuvdc_mul #(.AW(NW), .BW(NW)) u_dd (
        .clk(clk), .en(en), .a(dotm_reg), .b(dotm_reg), .p(dd_w)
    );

    // stage 6: squared cross norm by Lagrange identity
    logic            v6_reg, z6_reg;
    logic [DENW-1:0] den6_reg, rem6_reg;

    // restoring divider, one quotient bit per stage
    logic [RMW-1:0]  div_r_in  [QW];
    logic [DENW-1:0] div_d_in  [QW];
    logic [QW-1:0]   div_q_in  [QW];
    logic            div_z_in  [QW];
    logic            div_v_in  [QW];
    logic            div_ge    [QW];
    logic [RMW-1:0]  dr_reg    [QW], dr_next [QW];
    logic [QW-1:0]   dq_reg    [QW], dq_next [QW];
    logic [DENW-1:0] dden_reg  [QW];
    logic            dz_reg    [QW];
    logic            dvl_reg   [QW];

    always_comb
    begin
        div_r_in[0] = RMW'(rem6_reg);
        div_d_in[0] = den6_reg;
        div_q_in[0] = '0;
        div_z_in[0] = z6_reg;
        div_v_in[0] = v6_reg;
        for (int i = 1; i < QW; i++)
        begin
            div_r_in[i] = dr_reg[i-1] << 1;
            div_d_in[i] = dden_reg[i-1];
            div_q_in[i] = dq_reg[i-1];
            div_z_in[i] = dz_reg[i-1];
            div_v_in[i] = dvl_reg[i-1];
        end
        for (int i = 0; i < QW; i++)
        begin
            div_ge[i]  = div_r_in[i] >= RMW'(div_d_in[i]);
            dr_next[i] = div_ge[i] ? (div_r_in[i] - RMW'(div_d_in[i])) : div_r_in[i];
            dq_next[i] = {div_q_in[i][QW-2:0], div_ge[i]};
        end
    end

    // square root, one root bit per stage
    logic [SW-1:0]   sqr_r_in [SW];
    logic [QW-1:0]   sqr_q_in [SW];
    logic            sqr_z_in [SW];
    logic            sqr_v_in [SW];
    logic [SW-1:0]   sqr_cand [SW];
    logic [SQ2W-1:0] sqr_csq  [SW];
    logic [SW-1:0]   sr_reg   [SW], sr_next [SW];
    logic [QW-1:0]   sq_reg   [SW];
    logic            sz_reg   [SW];
    logic            svl_reg  [SW];

    always_comb
    begin
        sqr_r_in[0] = '0;
        sqr_q_in[0] = dq_reg[QW-1];
        sqr_z_in[0] = dz_reg[QW-1];
        sqr_v_in[0] = dvl_reg[QW-1];
        for (int j = 1; j < SW; j++)
        begin
            sqr_r_in[j] = sr_reg[j-1];
            sqr_q_in[j] = sq_reg[j-1];
            sqr_z_in[j] = sz_reg[j-1];
            sqr_v_in[j] = svl_reg[j-1];
        end
        for (int j = 0; j < SW; j++)
        begin
            sqr_cand[j] = sqr_r_in[j] | (SW'(1) << (SW - 1 - j));
            sqr_csq[j]  = SQ2W'(sqr_cand[j]) * SQ2W'(sqr_cand[j]);
            sr_next[j]  = (sqr_csq[j] <= SQ2W'(sqr_q_in[j])) ? sqr_cand[j] : sqr_r_in[j];
        end
    end

    // colour mix into the output buffer
    logic [SW-1:0]   sine;
    logic [RESW-1:0] res_next;
    logic [RESW-1:0] res_reg [2];

    assign sine = sz_reg[SW-1] ? ONE : sr_reg[SW-1];
    assign res_next = {chan_mix(base_red_reg, gain_red_reg, sine),
                       chan_mix(base_green_reg, gain_green_reg, sine),
                       chan_mix(base_blue_reg, gain_blue_reg, sine),
                       sine};

    assign push     = en && svl_reg[SW-1];
    assign pop      = out_valid && out_ready;
    assign wr_idx   = !((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop));
    assign cnt_next = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            cnt_reg <= 2'd0;
            for (int i = 0; i < MUL_LAT; i++)
            begin
                m1_v_reg[i] <= 1'b0;
                m2_v_reg[i] <= 1'b0;
            end
            for (int i = 0; i < QW; i++)
            begin
                dvl_reg[i] <= 1'b0;
            end
            for (int j = 0; j < SW; j++)
            begin
                svl_reg[j] <= 1'b0;
            end
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (en)
            begin
                v1_reg      <= in_valid;
                v2_reg      <= v1_reg;
                v3_reg      <= v2_reg;
                v4_reg      <= v3_reg;
                m1_v_reg[0] <= v4_reg;
                for (int i = 1; i < MUL_LAT; i++)
                begin
                    m1_v_reg[i] <= m1_v_reg[i-1];
                    m2_v_reg[i] <= m2_v_reg[i-1];
                end
                v5_reg      <= m1_v_reg[MUL_LAT-1];
                m2_v_reg[0] <= v5_reg;
                v6_reg      <= m2_v_reg[MUL_LAT-1];
                for (int i = 0; i < QW; i++)
                begin
                    dvl_reg[i] <= div_v_in[i];
                end
                for (int j = 0; j < SW; j++)
                begin
                    svl_reg[j] <= sqr_v_in[j];
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg  <= e1_next;
            e2_reg  <= e2_next;
            t1u_reg <= t1u_next;
            t1v_reg <= t1v_next;
            t2u_reg <= t2u_next;
            t2v_reg <= t2v_next;
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            pc_reg  <= pc_next;
            pd_reg  <= pd_next;
            du_reg  <= du_next;
            dv_reg  <= dv_next;
            dum_reg <= dum_next;
            dvm_reg <= dvm_next;
            sg4_reg <= sg4_next;
            z4_reg  <= z4_next;
            m1_z_reg[0]  <= z4_reg;
            m1_sg_reg[0] <= sg4_reg;
            for (int i = 1; i < MUL_LAT; i++)
            begin
                m1_z_reg[i]  <= m1_z_reg[i-1];
                m1_sg_reg[i] <= m1_sg_reg[i-1];
                m2_z_reg[i]  <= m2_z_reg[i-1];
            end
            nu_reg      <= nu_next;
            nv_reg      <= nv_next;
            dotm_reg    <= dotm_next;
            z5_reg      <= m1_z_reg[MUL_LAT-1];
            m2_z_reg[0] <= z5_reg;
            den6_reg    <= den_w;
            rem6_reg    <= den_w - dd_w;
            z6_reg      <= m2_z_reg[MUL_LAT-1];
            dr_reg      <= dr_next;
            dq_reg      <= dq_next;
            dden_reg    <= div_d_in;
            dz_reg      <= div_z_in;
            sr_reg      <= sr_next;
            sq_reg      <= sqr_q_in;
            sz_reg      <= sqr_z_in;
        end
        if (push && !wr_idx)
            res_reg[0] <= res_next;
        else if (pop)
            res_reg[0] <= res_reg[1];
        if (push && wr_idx)
            res_reg[1] <= res_next;
    end

    assign out_valid = cnt_reg != 2'd0;
    assign red        = res_reg[0][RESW-1 -: CHAN_W];
    assign green      = res_reg[0][RESW-CHAN_W-1 -: CHAN_W];
    assign blue       = res_reg[0][SW+CHAN_W-1 -: CHAN_W];
    assign distortion = res_reg[0][SW-1:0];
    assign alpha      = ALPHA_OPAQUE;

    `TUVDC_ASSERT_SAME(a_buf_no_overflow, push && !pop, cnt_reg != 2'd2)
    `TUVDC_ASSERT_NEXT(a_push_shows, push, out_valid)
    `TUVDC_ASSERT_SAME(a_sine_bound, out_valid, distortion <= ONE)
    `TUVDC_ASSERT_SAME(a_quot_bound, dvl_reg[QW-1] && !dz_reg[QW-1], dq_reg[QW-1] <= Q_MAX)

endmodule

`default_nettype wire

/* tb/triangle_uv_distortion_color_test.sv */
`default_nettype none

module triangle_uv_distortion_color_test;

    import tuvdc_pkg::*;

    localparam int LATENCY = 39;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES = 8;
    localparam int RANDOM_PER_PHASE = 225;

    typedef logic signed [191:0] wide_t;

    typedef struct packed {
        logic [8:0][15:0] pos;
        logic [2:0][31:0] uv;
    } triangle_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [8:0] distortion;
    } color_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] vertex0_x, vertex0_y, vertex0_z;
    logic signed [15:0] vertex1_x, vertex1_y, vertex1_z;
    logic signed [15:0] vertex2_x, vertex2_y, vertex2_z;
    logic [31:0] uv0, uv1, uv2;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CHAN_W-1:0] cfg_data;
    logic out_valid;
    logic out_ready;
    logic [7:0] red, green, blue, alpha;
    logic [8:0] distortion;

    triangle_t pending_tris[$];
    color_t colors_due[$];
    triangle_t held_tri;
    logic [7:0] base_r, base_g, base_b, gain_r, gain_g, gain_b;
    int send_gap;
    int stall_left;
    int cycles;
    int errors;
    int accepted;
    int checked;
    bit calm;

    triangle_uv_distortion_color dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .vertex0_x(vertex0_x), .vertex0_y(vertex0_y), .vertex0_z(vertex0_z),
        .vertex1_x(vertex1_x), .vertex1_y(vertex1_y), .vertex1_z(vertex1_z),
        .vertex2_x(vertex2_x), .vertex2_y(vertex2_y), .vertex2_z(vertex2_z),
        .uv0(uv0), .uv1(uv1), .uv2(uv2),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .red(red), .green(green), .blue(blue), .alpha(alpha),
        .distortion(distortion)
    );

    function automatic logic [7:0] shade(logic [7:0] base, logic [7:0] gain, int s);
        int v;
        v = base + ((gain * s) >> 8);
        return (v > 255) ? CHAN_MAX : v[7:0];
    endfunction

    function automatic color_t predict_color(triangle_t t);
        wide_t e1[3], e2[3], du[3], dv[3], cr[3];
        wide_t u0, v0, t1u, t1v, t2u, t2v, nu, nv, num, den, trial;
        int lo, hi, mid, k;
        color_t c;
        u0 = $signed(t.uv[0][31:16]);
        v0 = $signed(t.uv[0][15:0]);
        t1u = wide_t'($signed(t.uv[1][31:16])) - u0;
        t1v = wide_t'($signed(t.uv[1][15:0])) - v0;
        t2u = wide_t'($signed(t.uv[2][31:16])) - u0;
        t2v = wide_t'($signed(t.uv[2][15:0])) - v0;
        for (k = 0; k < 3; k++)
        begin
            e1[k] = wide_t'($signed(t.pos[3 + k])) - wide_t'($signed(t.pos[k]));
            e2[k] = wide_t'($signed(t.pos[6 + k])) - wide_t'($signed(t.pos[k]));
            du[k] = t2v * e1[k] - t1v * e2[k];
            dv[k] = t1u * e2[k] - t2u * e1[k];
        end
        for (k = 0; k < 3; k++)
            cr[k] = du[(k + 1) % 3] * dv[(k + 2) % 3] - du[(k + 2) % 3] * dv[(k + 1) % 3];
        nu = du[0] * du[0] + du[1] * du[1] + du[2] * du[2];
        nv = dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2];
        if (nu == 0 || nv == 0)
            lo = 256;
        else
        begin
            num = (cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2]) <<< 16;
            den = nu * nv;
            lo = 0;
            hi = 256;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                trial = wide_t'(mid * mid) * den;
                if (trial <= num)
                    lo = mid;
                else
                    hi = mid - 1;
            end
        end
        c.red = shade(base_r, gain_r, lo);
        c.green = shade(base_g, gain_g, lo);
        c.blue = shade(base_b, gain_b, lo);
        c.alpha = ALPHA_OPAQUE;
        c.distortion = lo[8:0];
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pack_uv(int u, int v);
        logic [15:0] uh, vh;
        uh = u[15:0];
        vh = v[15:0];
        return {uh, vh};
    endfunction

    function automatic triangle_t build_tri(int ax, int ay, int az, int bx, int by, int bz,
                                           int cx, int cy, int cz,
                                           logic [31:0] a, logic [31:0] b, logic [31:0] c);
        triangle_t t;
        t.pos[0] = ax[15:0]; t.pos[1] = ay[15:0]; t.pos[2] = az[15:0];
        t.pos[3] = bx[15:0]; t.pos[4] = by[15:0]; t.pos[5] = bz[15:0];
        t.pos[6] = cx[15:0]; t.pos[7] = cy[15:0]; t.pos[8] = cz[15:0];
        t.uv[0] = a; t.uv[1] = b; t.uv[2] = c;
        return t;
    endfunction

    function automatic triangle_t random_tri();
        triangle_t t;
        int r, k, sz;
        r = $urandom_range(0, 99);
        for (k = 0; k < 9; k++)
            t.pos[k] = 16'($urandom());
        for (k = 0; k < 3; k++)
            t.uv[k] = $urandom();
        if (r >= 55)
        begin
            sz = (r < 85) ? 8 : 300;
            for (k = 0; k < 9; k++)
                t.pos[k] = 16'($signed($urandom_range(0, 2 * sz)) - sz);
            for (k = 0; k < 3; k++)
                t.uv[k] = pack_uv($urandom_range(0, 2 * sz) - sz, $urandom_range(0, 2 * sz) - sz);
        end
        if (r >= 92)
        begin
            if (r[0])
                t.pos[8:6] = t.pos[2:0];
            else
                t.uv[2] = t.uv[1];
        end
        return t;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BASE_RED: base_r = value;
            REG_BASE_GREEN: base_g = value;
            REG_BASE_BLUE: base_b = value;
            REG_GAIN_RED: gain_r = value;
            REG_GAIN_GREEN: gain_g = value;
            REG_GAIN_BLUE: gain_b = value;
            default: ;
        endcase
    endtask

    task automatic drain();
        do @(posedge clk); while (pending_tris.size() != 0 || in_valid || colors_due.size() != 0);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout at %0t: %0d words still due", $time, colors_due.size());
            $display("triangle_uv_distortion_color_test: FAIL");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                colors_due.push_back(predict_color(held_tri));
                accepted++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_tris.size() != 0)
                begin
                    held_tri = pending_tris.pop_front();
                    {vertex0_x, vertex0_y, vertex0_z} <=
                        {held_tri.pos[0], held_tri.pos[1], held_tri.pos[2]};
                    {vertex1_x, vertex1_y, vertex1_z} <=
                        {held_tri.pos[3], held_tri.pos[4], held_tri.pos[5]};
                    {vertex2_x, vertex2_y, vertex2_z} <=
                        {held_tri.pos[6], held_tri.pos[7], held_tri.pos[8]};
                    {uv0, uv1, uv2} <= {held_tri.uv[0], held_tri.uv[1], held_tri.uv[2]};
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                color_t want, got;
                got = '{red, green, blue, alpha, distortion};
                if (colors_due.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = colors_due.pop_front();
                    checked++;
                    if (got.red !== want.red)
                        $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
                    if (got.green !== want.green)
                        $display("%0t: green expected %0d actual %0d",
                                 $time, want.green, got.green);
                    if (got.blue !== want.blue)
                        $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
                    if (got.alpha !== want.alpha)
                        $display("%0t: alpha expected %0d actual %0d",
                                 $time, want.alpha, got.alpha);
                    if (got.distortion !== want.distortion)
                        $display("%0t: distortion expected %0d actual %0d",
                                 $time, want.distortion, got.distortion);
                    if (got !== want)
                        errors++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        int p, n, k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        out_ready = 1'b0;
        {vertex0_x, vertex0_y, vertex0_z} = '0;
        {vertex1_x, vertex1_y, vertex1_z} = '0;
        {vertex2_x, vertex2_y, vertex2_z} = '0;
        {uv0, uv1, uv2} = '0;
        held_tri = '0;
        send_gap = 0;
        stall_left = 0;
        cycles = 0;
        errors = 0;
        accepted = 0;
        checked = 0;
        calm = 1'b0;
        base_r = 8'd0; base_g = 8'd0; base_b = 8'd0;
        gain_r = 8'd255; gain_g = 8'd255; gain_b = 8'd255;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < PHASES; p++)
        begin
            calm = (p == 4);
            case (p)
                0: ;
                1:
                begin
                    for (k = REG_BASE_RED; k <= REG_GAIN_BLUE; k++)
                        write_reg(CFG_IDX_W'(k), 8'd255);
                end
                2:
                begin
                    for (k = REG_BASE_RED; k <= REG_GAIN_BLUE; k++)
                        write_reg(CFG_IDX_W'(k), 8'd0);
                end
                3:
                begin
                    write_reg(CFG_IDX_W'(REG_GAIN_BLUE + 1), 8'($urandom()));
                    write_reg(CFG_IDX_W'(REG_GAIN_BLUE + 2), 8'($urandom()));
                    write_reg(REG_GAIN_RED, 8'd255);
                    write_reg(REG_BASE_GREEN, 8'd128);
                end
                default:
                begin
                    for (k = REG_BASE_RED; k <= REG_GAIN_BLUE; k++)
                        write_reg(CFG_IDX_W'(k), 8'($urandom()));
                end
            endcase
            if (p < 2)
            begin
                pending_tris.push_back('0);
                pending_tris.push_back(build_tri(0, 0, 0, 1, 0, 0, 0, 1, 0,
                    pack_uv(0, 0), pack_uv(1, 0), pack_uv(0, 1)));
                pending_tris.push_back(build_tri(0, 0, 0, 1, 0, 0, 2, 0, 0,
                    pack_uv(0, 0), pack_uv(1, 0), pack_uv(0, 1)));
                pending_tris.push_back(build_tri(0, 0, 0, 5, 3, 1, -2, 7, 4,
                    pack_uv(0, 0), pack_uv(1, 0), pack_uv(2, 0)));
                pending_tris.push_back(build_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                    -32768, 32767, -32768, 32'h80008000, 32'h7FFF7FFF, 32'h80007FFF));
                pending_tris.push_back(build_tri(32767, -32768, 0, -32768, 32767, 32767,
                    32767, 32767, -32768, 32'h7FFF8000, 32'h80007FFF, 32'h7FFF7FFF));
                pending_tris.push_back(build_tri(1, 2, 3, 4, 6, 8, 9, 5, 1,
                    pack_uv(3, 3), pack_uv(3, 3), pack_uv(-4, 9)));
                pending_tris.push_back(build_tri(0, 0, 0, 100, 0, 0, 99, 1, 0,
                    pack_uv(0, 0), pack_uv(100, 0), pack_uv(99, 1)));
                pending_tris.push_back('1);
                pending_tris.push_back({30{8'hA5}});
            end
            n = (p == 0) ? 40 : RANDOM_PER_PHASE;
            for (k = 0; k < n; k++)
                pending_tris.push_back(random_tri());
            drain();
        end

        $display("covered %0d triangles over %0d register settings, %0d words checked",
                 accepted, PHASES, checked);
        $display("zero and parallel columns, right angles, extreme coordinates, saturation");
        if (errors == 0 && colors_due.size() == 0)
            $display("triangle_uv_distortion_color_test: PASS");
        else
            $display("triangle_uv_distortion_color_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/tuvdc_pkg.sv
design/tuvdc_mul.sv
design/triangle_uv_distortion_color.sv
tb/triangle_uv_distortion_color_test.sv
